[rtl/core/st2d_pkg.sv]
package st2d_pkg;

  localparam logic [1:0] ACT_LOAD  = 2'd0;
  localparam logic [1:0] ACT_BUILD = 2'd1;
  localparam logic [1:0] ACT_QUERY = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_BAD     = 2'd1;
  localparam logic [1:0] ST_NOBUILD = 2'd2;

  localparam logic [1:0] REG_ROWS = 2'd0;
  localparam logic [1:0] REG_COLS = 2'd1;
  localparam logic [1:0] REG_MODE = 2'd2;

  typedef struct packed {
    logic [1:0]         action;
    logic [3:0]         row_start;
    logic [3:0]         col_start;
    logic [3:0]         row_end;
    logic [3:0]         col_end;
    logic signed [31:0] cell_value;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] result_value;
    logic [1:0]         status;
  } out_item_t;

  function automatic logic [2:0] flog2(input logic [4:0] v);
    logic [2:0] k;
    k = 3'd0;
    for (int b = 1; b < 5; b++) begin
      if (v[b]) begin
        k = 3'(b);
      end
    end
    return k;
  endfunction

endpackage

[rtl/core/sparse_table_2d_range_min.sv]
// Load: S_LOAD, then the result in S_OUT. Query: four reads of one memory port, one per
// cycle, then combine through S_QACC and S_QOUT; a rejected query goes from S_QRD to S_OUT.
// Build: each table entry written takes S_BRA, S_BRB and S_BWR, as the store has a single
// read and write port. One transaction at a time: a new one is accepted only after the
// result is taken, back in S_IDLE. Synchronous reset clears control state and registers
// to rows 16, columns 16, minimum; the level store is undefined until written.
module sparse_table_2d_range_min (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  st2d_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output st2d_pkg::out_item_t out_data,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [4:0]          cfg_wdata
);

  // Address is {k1, k2, row, col}; 5 levels each way at 16 x 16.
  localparam int AW = 14;
  localparam logic [3:0] S_IDLE = 4'd0, S_LOAD = 4'd1, S_QRD = 4'd2, S_QACC = 4'd3,
                         S_QOUT = 4'd4, S_BRA = 4'd5, S_BRB = 4'd6, S_BWR = 4'd7,
                         S_BNEXT = 4'd8, S_OUT = 4'd9;

  logic [3:0]  state;
  logic [4:0]  rows_in_use, cols_in_use;
  logic        combine_mode, table_built;
  st2d_pkg::in_item_t item;
  st2d_pkg::out_item_t res;

  logic [31:0] mem [2**AW];
  logic [AW-1:0] raddr, waddr;
  logic [31:0] rdata, wdata, acc, opa;
  logic        we;

  logic [4:0] n, m;
  logic [2:0] ln, lm, k1, k2, qk1, qk2;
  logic [3:0] bi, bj;
  logic       phase;  // 0 row levels, 1 column levels
  logic [1:0] rdcnt;

  always_comb begin
    n = (rows_in_use == 5'd0) ? 5'd1 : (rows_in_use > 5'd16 ? 5'd16 : rows_in_use);
    m = (cols_in_use == 5'd0) ? 5'd1 : (cols_in_use > 5'd16 ? 5'd16 : cols_in_use);
    ln = st2d_pkg::flog2(n) + 3'd1;
    lm = st2d_pkg::flog2(m) + 3'd1;
  end

  function automatic logic [31:0] pick(input logic [31:0] a, input logic [31:0] b,
                                       input logic mx);
    logic lt;
    lt = $signed(a) < $signed(b);
    return (mx ? !lt : lt) ? a : b;
  endfunction

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  logic [4:0] qsr, qsc;
  logic [3:0] qrb, qcb;
  logic       qbad;
  always_comb begin
    qsr = 5'(item.row_end) - 5'(item.row_start) + 5'd1;
    qsc = 5'(item.col_end) - 5'(item.col_start) + 5'd1;
    qk1 = st2d_pkg::flog2(qsr);
    qk2 = st2d_pkg::flog2(qsc);
    qrb = 4'(5'(item.row_end) + 5'd1 - (5'd1 << qk1));
    qcb = 4'(5'(item.col_end) + 5'd1 - (5'd1 << qk2));
    qbad = (item.row_start > item.row_end) || (item.col_start > item.col_end) ||
           (5'(item.row_end) >= n) || (5'(item.col_end) >= m);
  end

  // Read address for the current step.
  logic [3:0] half_r, half_c;
  always_comb begin
    half_r = 4'(5'd1 << (k1 - 3'd1));
    half_c = 4'(5'd1 << (k2 - 3'd1));
    raddr = '0;
    unique case (state)
      S_QRD: begin
        unique case (rdcnt)
          2'd0: raddr = {qk1, qk2, item.row_start, item.col_start};
          2'd1: raddr = {qk1, qk2, qrb, item.col_start};
          2'd2: raddr = {qk1, qk2, item.row_start, qcb};
          default: raddr = {qk1, qk2, qrb, qcb};
        endcase
      end
      S_BRA: raddr = phase ? {k1, k2 - 3'd1, bi, bj} : {k1 - 3'd1, 3'd0, bi, bj};
      S_BRB: raddr = phase ? {k1, k2 - 3'd1, bi, bj + half_c}
                           : {k1 - 3'd1, 3'd0, bi + half_r, bj};
      default: raddr = '0;
    endcase
  end

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_OUT);
  assign out_data  = res;

  // Build sweep bounds.
  logic [5:0] i_lim, j_lim;
  always_comb begin
    i_lim = 6'(n) - (6'd1 << k1);
    j_lim = phase ? 6'(m) - (6'd1 << k2) : 6'(m) - 6'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      we <= 1'b0;
    end else begin
      we <= (state == S_BWR) ||
            (state == S_LOAD && 5'(item.row_start) < n && 5'(item.col_start) < m);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      rows_in_use <= 5'd16;
      cols_in_use <= 5'd16;
      combine_mode <= 1'b0;
      table_built <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          st2d_pkg::REG_ROWS: begin rows_in_use <= cfg_wdata; table_built <= 1'b0; end
          st2d_pkg::REG_COLS: begin cols_in_use <= cfg_wdata; table_built <= 1'b0; end
          st2d_pkg::REG_MODE: begin combine_mode <= cfg_wdata[0]; table_built <= 1'b0; end
          default: ;
        endcase
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            item <= in_data;
            res <= '0;
            unique case (in_data.action)
              st2d_pkg::ACT_LOAD: state <= S_LOAD;
              st2d_pkg::ACT_BUILD: begin
                phase <= 1'b0; k1 <= 3'd1; k2 <= 3'd0; bi <= '0; bj <= '0;
                state <= S_BNEXT;
              end
              st2d_pkg::ACT_QUERY: begin rdcnt <= '0; state <= S_QRD; end
              default: state <= S_OUT;
            endcase
          end
        end
        S_LOAD: begin
          if (5'(item.row_start) < n && 5'(item.col_start) < m) begin
            waddr <= {3'd0, 3'd0, item.row_start, item.col_start};
            wdata <= item.cell_value;
          end
          table_built <= 1'b0;
          state <= S_OUT;
        end
        S_QRD: begin
          if (qbad) begin
            res.status <= st2d_pkg::ST_BAD;
            state <= S_OUT;
          end else if (!table_built) begin
            res.status <= st2d_pkg::ST_NOBUILD;
            state <= S_OUT;
          end else begin
            rdcnt <= rdcnt + 2'd1;
            if (rdcnt == 2'd3) begin
              state <= S_QACC;
            end
            if (rdcnt != 2'd0) begin
              acc <= (rdcnt == 2'd1) ? rdata : pick(acc, rdata, combine_mode);
            end
          end
        end
        S_QACC: begin
          acc <= pick(acc, rdata, combine_mode);
          state <= S_QOUT;
        end
        S_QOUT: begin
          res.result_value <= acc;
          res.status <= st2d_pkg::ST_OK;
          state <= S_OUT;
        end
        S_BNEXT: begin
          // Skip empty levels and advance through the level order.
          if (!phase && k1 >= ln) begin
            phase <= 1'b1; k1 <= 3'd0; k2 <= 3'd1;
          end else if (phase && k2 >= lm) begin
            k1 <= k1 + 3'd1; k2 <= 3'd1;
            if (k1 + 3'd1 >= ln) begin
              table_built <= 1'b1;
              state <= S_OUT;
            end
          end else if (phase && k1 >= ln) begin
            table_built <= 1'b1;
            state <= S_OUT;
          end else begin
            bi <= '0; bj <= '0;
            state <= S_BRA;
          end
        end
        S_BRA: state <= S_BRB;
        S_BRB: begin
          opa <= rdata;
          state <= S_BWR;
        end
        S_BWR: begin
          waddr <= phase ? {k1, k2, bi, bj} : {k1, 3'd0, bi, bj};
          wdata <= pick(opa, rdata, combine_mode);
          if (6'(bj) < j_lim) begin
            bj <= bj + 4'd1;
            state <= S_BRA;
          end else if (6'(bi) < i_lim) begin
            bj <= '0; bi <= bi + 4'd1;
            state <= S_BRA;
          end else begin
            if (phase) begin
              k2 <= k2 + 3'd1;
            end else begin
              k1 <= k1 + 3'd1;
            end
            state <= S_BNEXT;
          end
        end
        S_OUT: if (out_ready) begin state <= S_IDLE; end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Writes within one level never touch the level being read, and a level change passes
  // through S_BNEXT, so the last write has landed before the next level is read.
  a_one_side: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid)) else $error("ready and valid together");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data)) else $error("result dropped");
  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status != st2d_pkg::ST_OK |-> out_data.result_value == '0)
    else $error("nonzero value with error status");

endmodule

[dv/sparse_table_2d_range_min_tb.sv]
`timescale 1ns / 1ps

module sparse_table_2d_range_min_tb;

  typedef struct {
    st2d_pkg::in_item_t  item;
    bit                  typed;
    st2d_pkg::out_item_t want;
  } dir_row_t;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_ready;
  st2d_pkg::in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  st2d_pkg::out_item_t out_data;
  logic      cfg_we = 1'b0;
  logic [1:0] cfg_index = st2d_pkg::REG_ROWS;
  logic [4:0] cfg_wdata = '0;

  logic signed [31:0] tbl [0:4][0:4][0:15][0:15];
  logic [4:0]  rows_cfg;
  logic [4:0]  cols_cfg;
  logic        max_mode;
  bit          built;
  st2d_pkg::out_item_t pending_results [$];
  int          errors = 0;
  int          send_idle = 0;
  int          recv_idle = 0;
  dir_row_t    dir_rows [16];

  sparse_table_2d_range_min u_dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #50_000_000;
    $display("sparse_table_2d_range_min_tb NOT OK");
    $finish;
  end

  function automatic int dim(input logic [4:0] v);
    if (v == 0) return 1;
    if (v > 16) return 16;
    return int'(v);
  endfunction

  function automatic int lg(input int v);
    int k;
    k = 0;
    while (v > 1) begin
      v = v >> 1;
      k++;
    end
    return k;
  endfunction

  function automatic logic signed [31:0] pick(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
    if (max_mode) return (a > b) ? a : b;
    return (a < b) ? a : b;
  endfunction

  function automatic st2d_pkg::in_item_t mk(input logic [1:0] act, input int r1,
                                            input int c1, input int r2, input int c2,
                                            input logic [31:0] v);
    st2d_pkg::in_item_t it;
    it.action = act;
    it.row_start = 4'(r1);
    it.col_start = 4'(c1);
    it.row_end = 4'(r2);
    it.col_end = 4'(c2);
    it.cell_value = v;
    return it;
  endfunction

  function automatic st2d_pkg::out_item_t res(input logic [31:0] v, input logic [1:0] st);
    st2d_pkg::out_item_t o;
    o.result_value = v;
    o.status = st;
    return o;
  endfunction

  task automatic rebuild_table();
    int n, m, half;
    n = dim(rows_cfg);
    m = dim(cols_cfg);
    for (int k1 = 1; k1 <= lg(n); k1++) begin
      half = 1 << (k1 - 1);
      for (int i = 0; i + (1 << k1) <= n; i++)
        for (int j = 0; j < m; j++)
          tbl[k1][0][i][j] = pick(tbl[k1-1][0][i][j], tbl[k1-1][0][i+half][j]);
    end
    for (int k1 = 0; k1 <= lg(n); k1++)
      for (int k2 = 1; k2 <= lg(m); k2++) begin
        half = 1 << (k2 - 1);
        for (int i = 0; i + (1 << k1) <= n; i++)
          for (int j = 0; j + (1 << k2) <= m; j++)
            tbl[k1][k2][i][j] = pick(tbl[k1][k2-1][i][j], tbl[k1][k2-1][i][j+half]);
      end
    built = 1'b1;
  endtask

  task automatic predict_range(input st2d_pkg::in_item_t it, output st2d_pkg::out_item_t o);
    int n, m, r1, c1, r2, c2, k1, k2, rb, cb;
    logic signed [31:0] acc;
    n = dim(rows_cfg);
    m = dim(cols_cfg);
    r1 = it.row_start;
    c1 = it.col_start;
    r2 = it.row_end;
    c2 = it.col_end;
    o = res('0, st2d_pkg::ST_OK);
    case (it.action)
      st2d_pkg::ACT_LOAD: begin
        if (r1 < n && c1 < m) tbl[0][0][r1][c1] = it.cell_value;
        built = 1'b0;
      end
      st2d_pkg::ACT_BUILD: rebuild_table();
      st2d_pkg::ACT_QUERY: begin
        if (r1 > r2 || c1 > c2 || r2 >= n || c2 >= m) begin
          o.status = st2d_pkg::ST_BAD;
        end else if (!built) begin
          o.status = st2d_pkg::ST_NOBUILD;
        end else begin
          k1 = lg(r2 - r1 + 1);
          k2 = lg(c2 - c1 + 1);
          rb = r2 + 1 - (1 << k1);
          cb = c2 + 1 - (1 << k2);
          acc = tbl[k1][k2][r1][c1];
          acc = pick(acc, tbl[k1][k2][rb][c1]);
          acc = pick(acc, tbl[k1][k2][r1][cb]);
          acc = pick(acc, tbl[k1][k2][rb][cb]);
          o.result_value = acc;
        end
      end
      default: ;
    endcase
  endtask

  task automatic send(input st2d_pkg::in_item_t it, input bit typed,
                      input st2d_pkg::out_item_t want);
    st2d_pkg::out_item_t o;
    while ($urandom_range(99) < send_idle) @(negedge clk);
    in_valid = 1'b1;
    in_data = it;
    do @(posedge clk); while (!in_ready);
    predict_range(it, o);
    pending_results.push_back(typed ? want : o);
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic send_plain(input st2d_pkg::in_item_t it);
    send(it, 1'b0, '0);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [4:0] v);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = v;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      st2d_pkg::REG_ROWS: rows_cfg = v;
      st2d_pkg::REG_COLS: cols_cfg = v;
      default:  max_mode = v[0];
    endcase
    built = 1'b0;
  endtask

  task automatic drain();
    while (pending_results.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
  endtask

  function automatic logic [31:0] rand_value();
    case ($urandom_range(9))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'hffff_ffff;
      3: return 32'h0;
      default: return $urandom;
    endcase
  endfunction

  task automatic random_query(input int n, input int m);
    int r1, r2, c1, c2;
    if ($urandom_range(99) < 85) begin
      r1 = $urandom_range(n - 1);
      r2 = $urandom_range(n - 1, r1);
      c1 = $urandom_range(m - 1);
      c2 = $urandom_range(m - 1, c1);
      send_plain(mk(st2d_pkg::ACT_QUERY, r1, c1, r2, c2, $urandom));
    end else begin
      send_plain(mk(st2d_pkg::ACT_QUERY, $urandom_range(15), $urandom_range(15),
                    $urandom_range(15), $urandom_range(15), $urandom));
    end
  endtask

  always @(negedge clk) begin
    out_ready = ($urandom_range(99) >= recv_idle);
  end

  always @(posedge clk) begin
    st2d_pkg::out_item_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected transaction: result_value %0d status %0d",
               out_data.result_value, out_data.status);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (out_data.result_value !== want.result_value) begin
          $error("result_value: expected %0d, actual %0d", want.result_value,
                 out_data.result_value);
          errors++;
        end
        if (out_data.status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, out_data.status);
          errors++;
        end
      end
    end
  end

  initial begin
    logic [4:0] cfg_sets [6][3];
    int n, m, sent;
    rows_cfg = 5'd16;
    cols_cfg = 5'd16;
    max_mode = 1'b0;
    built = 1'b0;
    dir_rows[0]  = '{mk(st2d_pkg::ACT_QUERY, 0, 0, 15, 15, 0), 1'b1,
                     res(0, st2d_pkg::ST_NOBUILD)};
    dir_rows[1]  = '{mk(st2d_pkg::ACT_QUERY, 5, 0, 4, 15, 0), 1'b1, res(0, st2d_pkg::ST_BAD)};
    dir_rows[2]  = '{mk(st2d_pkg::ACT_QUERY, 0, 9, 15, 8, 0), 1'b1, res(0, st2d_pkg::ST_BAD)};
    dir_rows[3]  = '{mk(2'd3, 1, 2, 3, 4, 5), 1'b1, res(0, st2d_pkg::ST_OK)};
    dir_rows[4]  = '{mk(st2d_pkg::ACT_BUILD, 0, 0, 0, 0, 0), 1'b1, res(0, st2d_pkg::ST_OK)};
    dir_rows[5]  = '{mk(st2d_pkg::ACT_QUERY, 0, 0, 15, 15, 0), 1'b1,
                     res(32'h8000_0000, st2d_pkg::ST_OK)};
    dir_rows[6]  = '{mk(st2d_pkg::ACT_QUERY, 15, 15, 15, 15, 0), 1'b1,
                     res(32'h7fff_ffff, st2d_pkg::ST_OK)};
    dir_rows[7]  = '{mk(st2d_pkg::ACT_QUERY, 0, 0, 0, 0, 0), 1'b1,
                     res(32'h8000_0000, st2d_pkg::ST_OK)};
    dir_rows[8]  = '{mk(st2d_pkg::ACT_QUERY, 3, 2, 9, 14, 0), 1'b0, res(0, st2d_pkg::ST_OK)};
    dir_rows[9]  = '{mk(st2d_pkg::ACT_QUERY, 1, 1, 1, 1, 0), 1'b0, res(0, st2d_pkg::ST_OK)};
    dir_rows[10] = '{mk(st2d_pkg::ACT_LOAD, 15, 15, 0, 0, 5), 1'b1, res(0, st2d_pkg::ST_OK)};
    dir_rows[11] = '{mk(st2d_pkg::ACT_QUERY, 15, 15, 15, 15, 0), 1'b1,
                     res(0, st2d_pkg::ST_NOBUILD)};
    dir_rows[12] = '{mk(st2d_pkg::ACT_BUILD, 15, 15, 15, 15, 32'hffff_ffff), 1'b1,
                     res(0, st2d_pkg::ST_OK)};
    dir_rows[13] = '{mk(st2d_pkg::ACT_QUERY, 15, 15, 15, 15, 0), 1'b1,
                     res(5, st2d_pkg::ST_OK)};
    dir_rows[14] = '{mk(st2d_pkg::ACT_QUERY, 0, 5, 15, 5, 0), 1'b0, res(0, st2d_pkg::ST_OK)};
    dir_rows[15] = '{mk(2'd3, 15, 15, 15, 15, 32'hffff_ffff), 1'b1, res(0, st2d_pkg::ST_OK)};
    cfg_sets = '{'{5'd16, 5'd16, 5'd0}, '{5'd1, 5'd1, 5'd1}, '{5'd0, 5'd31, 5'd0},
                 '{5'd31, 5'd0, 5'd1}, '{5'($urandom_range(31)), 5'($urandom_range(31)), 5'd1},
                 '{5'($urandom_range(31)), 5'($urandom_range(31)), 5'd0}};
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    for (int r = 0; r < 16; r++)
      for (int c = 0; c < 16; c++) begin
        if (r == 0 && c == 0)
          send_plain(mk(st2d_pkg::ACT_LOAD, r, c, 0, 0, 32'h8000_0000));
        else if (r == 15 && c == 15)
          send_plain(mk(st2d_pkg::ACT_LOAD, r, c, 0, 0, 32'h7fff_ffff));
        else send_plain(mk(st2d_pkg::ACT_LOAD, r, c, $urandom_range(15), $urandom_range(15),
                           rand_value()));
      end
    foreach (dir_rows[i]) send(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want);

    for (int ph = 0; ph < 6; ph++) begin
      drain();
      write_reg(st2d_pkg::REG_ROWS, cfg_sets[ph][0]);
      write_reg(st2d_pkg::REG_COLS, cfg_sets[ph][1]);
      write_reg(st2d_pkg::REG_MODE, cfg_sets[ph][2]);
      send_idle = (ph / 2 == 0) ? 37 : (ph / 2 == 1) ? 59 : 0;
      recv_idle = (ph / 2 == 0) ? 59 : (ph / 2 == 1) ? 37 : 0;
      n = dim(rows_cfg);
      m = dim(cols_cfg);
      sent = 0;
      while (sent < 20) begin
        repeat ($urandom_range(3)) begin
          send_plain(mk(st2d_pkg::ACT_LOAD, $urandom_range(15), $urandom_range(15),
                        $urandom_range(15), $urandom_range(15), rand_value()));
          sent++;
        end
        if ($urandom_range(9) != 0) begin
          send_plain(mk(st2d_pkg::ACT_BUILD, $urandom_range(15), $urandom_range(15),
                        $urandom_range(15), $urandom_range(15), $urandom));
          sent++;
        end
        repeat ($urandom_range(12, 4)) begin
          if ($urandom_range(19) == 0)
            send_plain(mk(2'd3, $urandom_range(15), $urandom_range(15),
                          $urandom_range(15), $urandom_range(15), $urandom));
          else
            random_query(n, m);
          sent++;
        end
      end
    end
    drain();

    if (errors == 0) begin
      $display("sparse_table_2d_range_min_tb OK");
    end else begin
      $display("sparse_table_2d_range_min_tb NOT OK");
    end
    $finish;
  end

endmodule

[sparse_table_2d_range_min.f]
rtl/core/st2d_pkg.sv
rtl/core/sparse_table_2d_range_min.sv
dv/sparse_table_2d_range_min_tb.sv
